### design/pkst_pkg.sv
// ============================================================================
// pkst_pkg - port knock sequence tracker package
// Shared sizes, codes, request/response and table types, knock port select.
// ============================================================================
`default_nettype none

package pkst_pkg;

  localparam int PEER_SLOTS      = 16;
  localparam int MAX_KNOCK_PORTS = 8;
  localparam int SLOT_W          = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W           = 5;
  localparam int PADDR_W         = 6;
  localparam int PDATA_W         = 64;

  localparam logic [1:0] PEER_NONE     = 2'd0;
  localparam logic [1:0] PEER_INIT     = 2'd1;
  localparam logic [1:0] PEER_MATCHING = 2'd2;
  localparam logic [1:0] PEER_ALLOWED  = 2'd3;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam logic [2:0] REG_PORTS_LOW  = 3'd0;
  localparam logic [2:0] REG_PORTS_HIGH = 3'd1;
  localparam logic [2:0] REG_PORT_COUNT = 3'd2;
  localparam logic [2:0] REG_GAP_LIMIT  = 3'd3;
  localparam logic [2:0] REG_STRICT     = 3'd4;
  localparam logic [2:0] REG_TIME_CHECK = 3'd5;
  localparam logic [2:0] REG_CHECK_ONLY = 3'd6;

  typedef struct packed {
    logic        op;
    logic [31:0] src_ip;
    logic [15:0] dest_port;
    logic [31:0] now_sec;
    logic [31:0] now_minute;
  } pkst_req_t;

  typedef struct packed {
    logic             accepted;
    logic [1:0]       peer_state;
    logic             table_full;
    logic [CNT_W-1:0] removed_count;
  } pkst_rsp_t;

  typedef struct packed {
    logic [63:0] ports_low;
    logic [63:0] ports_high;
    logic [3:0]  port_count;
    logic [15:0] gap_limit_sec;
    logic        strict_mode;
    logic        time_check_enable;
    logic        check_only_mode;
  } pkst_cfg_t;

  typedef struct packed {
    logic [31:0] address;
    logic [3:0]  next_pos;
    logic [1:0]  status;
    logic [31:0] last_time;
    logic [31:0] login_minute;
  } pkst_entry_t;

  typedef struct packed {
    logic        en;
    logic        valid;
    logic        fields;
    pkst_entry_t entry;
  } pkst_wr_t;

  function automatic logic [15:0] knock_port(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [2:0] i);
    logic [63:0] w;
    w = i[2] ? hi : lo;
    return w[{i[1:0], 4'b0000} +: 16];
  endfunction

endpackage

`default_nettype wire

### design/pkst_cfg.sv
// ============================================================================
// pkst_cfg - configuration registers
// APB-style register file holding the knock sequence and mode bits.
// ============================================================================
`default_nettype none

module pkst_cfg (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [pkst_pkg::PADDR_W-1:0]  paddr,
  input  wire [pkst_pkg::PDATA_W-1:0]  pwdata,
  output logic [pkst_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output pkst_pkg::pkst_cfg_t          cfg
);
  import pkst_pkg::*;

  logic       wr;
  logic [2:0] sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign sel    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ports_low         <= '0;
      cfg.ports_high        <= '0;
      cfg.port_count        <= 4'd1;
      cfg.gap_limit_sec     <= '0;
      cfg.strict_mode       <= 1'b0;
      cfg.time_check_enable <= 1'b0;
      cfg.check_only_mode   <= 1'b0;
    end else if (wr) begin
      case (sel)
        REG_PORTS_LOW:  cfg.ports_low         <= pwdata;
        REG_PORTS_HIGH: cfg.ports_high        <= pwdata;
        REG_PORT_COUNT: cfg.port_count        <= pwdata[3:0];
        REG_GAP_LIMIT:  cfg.gap_limit_sec     <= pwdata[15:0];
        REG_STRICT:     cfg.strict_mode       <= pwdata[0];
        REG_TIME_CHECK: cfg.time_check_enable <= pwdata[0];
        REG_CHECK_ONLY: cfg.check_only_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PORTS_LOW:  prdata = cfg.ports_low;
      REG_PORTS_HIGH: prdata = cfg.ports_high;
      REG_PORT_COUNT: prdata = {60'd0, cfg.port_count};
      REG_GAP_LIMIT:  prdata = {48'd0, cfg.gap_limit_sec};
      REG_STRICT:     prdata = {63'd0, cfg.strict_mode};
      REG_TIME_CHECK: prdata = {63'd0, cfg.time_check_enable};
      REG_CHECK_ONLY: prdata = {63'd0, cfg.check_only_mode};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/pkst_table.sv
// ============================================================================
// pkst_table - peer table storage
// Per-slot valid flops plus entry fields; one shared read/write address.
// ============================================================================
`default_nettype none

module pkst_table (
  input  wire                         clk,
  input  wire                         rst,
  input  wire [pkst_pkg::SLOT_W-1:0]  idx,
  input  pkst_pkg::pkst_wr_t          wr,
  output logic                        rd_valid,
  output pkst_pkg::pkst_entry_t       rd_entry
);
  import pkst_pkg::*;

  logic        valid [PEER_SLOTS];
  pkst_entry_t entries [PEER_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (wr.en) begin
      valid[idx] <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.fields) begin
      entries[idx] <= wr.entry;
    end
  end

  assign rd_valid = valid[idx];
  assign rd_entry = entries[idx];

endmodule

`default_nettype wire

### design/pkst_engine.sv
// ============================================================================
// pkst_engine - scan sequencer and shared compare unit
// Walks the peer table one slot per cycle, then, for packet requests, applies one update step.
// ============================================================================
`default_nettype none

module pkst_engine (
  input  wire                  clk,
  input  wire                  rst,
  input  pkst_pkg::pkst_cfg_t  cfg,
  input  wire                  req_load,
  input  pkst_pkg::pkst_req_t  req_in,
  output logic                 ready,
  output logic                 rsp_valid,
  input  wire                  rsp_take,
  output pkst_pkg::pkst_rsp_t  rsp
);
  import pkst_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PEER_SLOTS - 1);

  logic [1:0]        state;
  logic [SLOT_W-1:0] cnt;
  pkst_req_t         req;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_ok;
  logic [SLOT_W-1:0] free_idx;
  logic [CNT_W-1:0]  removed;
  logic [CNT_W-1:0]  removed_next;

  logic [SLOT_W-1:0] tbl_idx;
  logic              rd_valid;
  pkst_entry_t       rd;
  pkst_wr_t          wr;
  pkst_wr_t          upd_wr;
  pkst_rsp_t         upd_rsp;

  logic              creating;
  logic [31:0]       last_src;
  logic [31:0]       diff;
  logic              exceeded;
  logic              addr_eq;
  logic              stale;
  logic [15:0]       port0;
  logic [3:0]        eff_count;

  pkst_table u_table (
    .clk      (clk),
    .rst      (rst),
    .idx      (tbl_idx),
    .wr       (wr),
    .rd_valid (rd_valid),
    .rd_entry (rd)
  );

  assign ready     = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign tbl_idx   = (state == S_UPDATE) ? (hit ? hit_idx : free_idx) : cnt;
  assign port0     = knock_port(cfg.ports_low, cfg.ports_high, 3'd0);
  assign creating  = (state == S_UPDATE) && !hit && !cfg.check_only_mode &&
                     (req.dest_port == port0) && free_ok;

  // shared time compare
  assign last_src  = creating ? req.now_sec : rd.last_time;
  assign diff      = last_src + {16'd0, cfg.gap_limit_sec} - req.now_sec;
  assign exceeded  = diff[31];

  assign addr_eq   = rd_valid && (rd.address == req.src_ip);
  assign stale     = rd_valid && (rd.login_minute != req.now_minute) && exceeded;
  assign removed_next = (stale && (removed != {CNT_W{1'b1}})) ? removed + 1'b1 : removed;

  always_comb begin
    if (cfg.port_count == 4'd0) begin
      eff_count = 4'd1;
    end else if (cfg.port_count > 4'(MAX_KNOCK_PORTS)) begin
      eff_count = 4'(MAX_KNOCK_PORTS);
    end else begin
      eff_count = cfg.port_count;
    end
  end

  always_comb begin
    logic        have;
    logic        wrong;
    logic        keep;
    logic [3:0]  pos;
    logic [3:0]  npos;
    pkst_entry_t e;
    upd_wr  = '0;
    upd_rsp = '0;
    have    = hit || creating;
    keep    = 1'b1;
    pos     = creating ? 4'd0 : rd.next_pos;
    npos    = pos + 4'd1;
    wrong   = (pos >= 4'(MAX_KNOCK_PORTS)) ||
              (knock_port(cfg.ports_low, cfg.ports_high, pos[2:0]) != req.dest_port);
    e.address      = req.src_ip;
    e.next_pos     = pos;
    e.status       = creating ? PEER_INIT : rd.status;
    e.last_time    = last_src;
    e.login_minute = creating ? 32'd0 : rd.login_minute;
    if (cfg.check_only_mode) begin
      upd_rsp.accepted   = hit && (rd.status == PEER_ALLOWED);
      upd_rsp.peer_state = hit ? rd.status : PEER_NONE;
    end else if (hit && (rd.status == PEER_ALLOWED)) begin
      upd_rsp.accepted   = 1'b1;
      upd_rsp.peer_state = PEER_ALLOWED;
    end else begin
      upd_rsp.table_full = !hit && (req.dest_port == port0) && !free_ok;
      if (have) begin
        if (wrong) begin
          if (cfg.strict_mode) begin
            e.next_pos = 4'd0;
            e.status   = PEER_INIT;
          end
        end else begin
          e.next_pos = npos;
          if (npos >= eff_count) begin
            e.status       = PEER_ALLOWED;
            e.login_minute = req.now_minute;
          end else if (cfg.time_check_enable && exceeded) begin
            keep = 1'b0;
          end else begin
            if (cfg.time_check_enable) begin
              e.last_time = req.now_sec;
            end
            e.status = PEER_MATCHING;
          end
        end
        upd_wr.en          = 1'b1;
        upd_wr.valid       = keep;
        upd_wr.fields      = 1'b1;
        upd_wr.entry       = e;
        upd_rsp.peer_state = keep ? e.status : PEER_NONE;
      end
    end
  end

  always_comb begin
    wr = '0;
    if (state == S_SCAN && req.op == OP_SWEEP && stale) begin
      wr.en    = 1'b1;
      wr.valid = 1'b0;
    end else if (state == S_UPDATE) begin
      wr = upd_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_load) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == LAST_SLOT) begin
            state <= (req.op == OP_SWEEP) ? S_RESP : S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req     <= req_in;
        cnt     <= '0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
        removed <= '0;
      end
      S_SCAN: begin
        cnt <= cnt + 1'b1;
        if (req.op == OP_PACKET) begin
          if (addr_eq && !hit) begin
            hit     <= 1'b1;
            hit_idx <= cnt;
          end
          if (!rd_valid && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= cnt;
          end
        end else begin
          removed <= removed_next;
          if (cnt == LAST_SLOT) begin
            rsp <= {1'b0, PEER_NONE, 1'b0, removed_next};
          end
        end
      end
      S_UPDATE: begin
        rsp <= upd_rsp;
      end
      default: ;
    endcase
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && rsp_take) |=> (state == S_IDLE))
    else $error("engine did not return to idle after handing off a response");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_SCAN || state == S_UPDATE))
    else $error("table written outside scan or update");

  a_sweep_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && req.op == OP_SWEEP) |->
      (!rsp.accepted && rsp.peer_state == PEER_NONE && !rsp.table_full))
    else $error("sweep response carries packet status");

  a_removed_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> (rsp.removed_count <= CNT_W'(PEER_SLOTS)))
    else $error("removed count beyond table size");

  a_packet_no_removed: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && req.op == OP_PACKET) |-> (rsp.removed_count == '0))
    else $error("packet response reports removals");

endmodule

`default_nettype wire

### design/port_knock_sequence_tracker.sv
// ============================================================================
// port_knock_sequence_tracker - port knock sequence tracker, top level
// Associative peer table tracking knock progress per source, with sweep.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     pkst_req_t
//   rsp      out        rsp_valid / rsp_stall     pkst_rsp_t
//   apb      in/out     psel penable pwrite pready paddr pwdata prdata
//
// A packet request runs a table scan and then an update step; a sweep runs
// the scan alone. The scan takes one peer slot per cycle through a single
// address/time compare unit. req_stall is high from acceptance until the
// result moves to the output register; a stalled result holds there while
// the next request is worked on. Reset clears all slots and loads register
// defaults.
// ============================================================================
`default_nettype none

module port_knock_sequence_tracker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  output logic                         req_stall,
  input  pkst_pkg::pkst_req_t          req,
  output logic                         rsp_valid,
  input  wire                          rsp_stall,
  output pkst_pkg::pkst_rsp_t          rsp,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [pkst_pkg::PADDR_W-1:0]  paddr,
  input  wire [pkst_pkg::PDATA_W-1:0]  pwdata,
  output logic [pkst_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import pkst_pkg::*;

  pkst_cfg_t cfg;
  logic      eng_ready;
  logic      eng_rsp_valid;
  logic      eng_take;
  pkst_rsp_t eng_rsp;

  pkst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req_stall = !eng_ready;
  assign eng_take  = eng_rsp_valid && (!rsp_valid || !rsp_stall);

  pkst_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_load  (req_valid && !req_stall),
    .req_in    (req),
    .ready     (eng_ready),
    .rsp_valid (eng_rsp_valid),
    .rsp_take  (eng_take),
    .rsp       (eng_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      rsp <= eng_rsp;
    end
  end

endmodule

`default_nettype wire
